/* hw/rtl/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// shared types and constants of the system control coprocessor
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CodeW = 5;
  localparam int unsigned CopW  = 2;

  // operation codes
  localparam logic [OpW-1:0] OP_READ  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_EXC   = 2'd2;
  localparam logic [OpW-1:0] OP_RFE   = 2'd3;

  // coprocessor register numbers
  localparam logic [IdxW-1:0] REG_BPC      = 6'd3;
  localparam logic [IdxW-1:0] REG_BDA      = 6'd5;
  localparam logic [IdxW-1:0] REG_JUMPDEST = 6'd6;
  localparam logic [IdxW-1:0] REG_DCIC     = 6'd7;
  localparam logic [IdxW-1:0] REG_BADVADDR = 6'd8;
  localparam logic [IdxW-1:0] REG_BDAM     = 6'd9;
  localparam logic [IdxW-1:0] REG_BPCM     = 6'd11;
  localparam logic [IdxW-1:0] REG_SR       = 6'd12;
  localparam logic [IdxW-1:0] REG_CAUSE    = 6'd13;
  localparam logic [IdxW-1:0] REG_EPC      = 6'd14;
  localparam logic [IdxW-1:0] REG_PRID     = 6'd15;

  // status stack masks and cause field positions
  localparam logic [DataW-1:0] MODE_BITS_MASK = 32'h0000_000f;
  localparam logic [DataW-1:0] PUSH_KEEP_MASK = 32'hffff_ffc0;
  localparam logic [DataW-1:0] POP_KEEP_MASK  = 32'hffff_fff0;
  localparam int unsigned      CAUSE_CODE_LSB = 2;
  localparam int unsigned      CAUSE_COP_LSB  = 28;
  localparam int unsigned      CAUSE_BD_BIT   = 31;

  // configuration register numbers
  localparam logic CFG_SR_MASK    = 1'b0;
  localparam logic CFG_CAUSE_MASK = 1'b1;
  localparam logic [DataW-1:0] SR_MASK_RST    = 32'hffff_ffff;
  localparam logic [DataW-1:0] CAUSE_MASK_RST = 32'h0000_0300;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  reg_index;
    logic [DataW-1:0] write_value;
    logic [DataW-1:0] fault_pc;
    logic [CodeW-1:0] exc_code;
    logic [CopW-1:0]  coproc;
    logic             branch_delay;
  } csc_req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             bad_access;
  } csc_rsp_t;

endpackage

/* hw/rtl/cpu_system_control_coprocessor.sv */
// ----------------------------------------------------------------------------
// cpu_system_control_coprocessor
// system control coprocessor: register access, exception entry and return
// ----------------------------------------------------------------------------
// pipeline: each request passes through the input register, then the result
//   register, before its result is offered
// throughput: one request per cycle while the result channel does not stall;
//   state commits in the register stage as a request leaves it, so back-to-back requests see each other's writes
// reset: synchronous active-low rst_n clears all coprocessor registers and
//   both pipeline valids, and loads the write masks with their defaults
module cpu_system_control_coprocessor (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] reg_index, [37:6] write_value, [69:38] fault_pc,
  // [74:70] exception_code, [76:75] coproc_number, [77] in_branch_delay, [79:78] zero
  input  logic [79:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_data
  output logic [31:0] out_tdata,
  // [0] bad_access
  output logic        out_tuser,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import csc_pkg::*;

  // write masks
  logic [DataW-1:0] sr_wmask_r;
  logic [DataW-1:0] cause_wmask_r;
  logic             cfg_wr;

  // input register stage
  logic             req_vld_r;
  csc_req_t         req_r;
  csc_req_t         req_in;
  logic             req_fire;

  // result register stage
  logic             out_vld_r;
  csc_rsp_t         rsp;
  csc_rsp_t         rsp_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_SR_MASK:    cfg_prdata = sr_wmask_r;
      CFG_CAUSE_MASK: cfg_prdata = cause_wmask_r;
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_wmask_r    <= SR_MASK_RST;
      cause_wmask_r <= CAUSE_MASK_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_SR_MASK) begin
        sr_wmask_r <= cfg_pwdata;
      end else begin
        cause_wmask_r <= cfg_pwdata;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  // the request register moves on when the result register is free or drains
  assign req_fire  = req_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~req_vld_r | req_fire;

  // unpack the request
  assign req_in.op           = in_tuser;
  assign req_in.reg_index    = in_tdata[5:0];
  assign req_in.write_value  = in_tdata[37:6];
  assign req_in.fault_pc     = in_tdata[69:38];
  assign req_in.exc_code     = in_tdata[74:70];
  assign req_in.coproc       = in_tdata[76:75];
  assign req_in.branch_delay = in_tdata[77];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_tready) begin
      req_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r <= req_in;
    end
  end

  // register state and access logic; state commits as the request leaves
  csc_regfile u_regfile (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_fire    (req_fire),
    .req         (req_r),
    .sr_wmask    (sr_wmask_r),
    .cause_wmask (cause_wmask_r),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (~out_vld_r | out_tready) begin
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = rsp_r.read_data;
  assign out_tuser  = rsp_r.bad_access;

endmodule

/* hw/rtl/csc_regfile.sv */
// ----------------------------------------------------------------------------
// csc_regfile
// coprocessor register state, register access and exception stack update
// ----------------------------------------------------------------------------
module csc_regfile (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_fire,
  input  csc_pkg::csc_req_t        req,
  input  logic [csc_pkg::DataW-1:0] sr_wmask,
  input  logic [csc_pkg::DataW-1:0] cause_wmask,
  output csc_pkg::csc_rsp_t        rsp
);
  import csc_pkg::*;

  logic [DataW-1:0] bpc_r, bda_r, jumpdest_r, dcic_r, bdam_r, bpcm_r;
  logic [DataW-1:0] sr_r, cause_r, epc_r;
  logic [DataW-1:0] bpc_nxt, bda_nxt, jumpdest_nxt, dcic_nxt, bdam_nxt, bpcm_nxt;
  logic [DataW-1:0] sr_nxt, cause_nxt, epc_nxt;
  logic [DataW-1:0] rd_data;
  logic             rd_mapped;
  logic             wr_ok;

  // read mux
  always_comb begin
    rd_data   = '0;
    rd_mapped = 1'b1;
    unique case (req.reg_index) inside
      REG_BPC:             rd_data = bpc_r;
      REG_BDA:             rd_data = bda_r;
      REG_JUMPDEST:        rd_data = jumpdest_r;
      REG_DCIC:            rd_data = dcic_r;
      REG_BDAM:            rd_data = bdam_r;
      REG_BPCM:            rd_data = bpcm_r;
      REG_SR:              rd_data = sr_r;
      REG_CAUSE:           rd_data = cause_r;
      REG_EPC:             rd_data = epc_r;
      REG_BADVADDR, REG_PRID: rd_data = '0;
      default:             rd_mapped = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    bpc_nxt      = bpc_r;
    bda_nxt      = bda_r;
    jumpdest_nxt = jumpdest_r;
    dcic_nxt     = dcic_r;
    bdam_nxt     = bdam_r;
    bpcm_nxt     = bpcm_r;
    sr_nxt       = sr_r;
    cause_nxt    = cause_r;
    epc_nxt      = epc_r;
    wr_ok        = 1'b1;
    rsp          = '0;
    unique case (req.op)
      OP_READ: begin
        rsp.read_data  = rd_data;
        rsp.bad_access = ~rd_mapped;
      end
      OP_WRITE: begin
        unique case (req.reg_index)
          REG_BPC:   bpc_nxt  = req.write_value;
          REG_BDA:   bda_nxt  = req.write_value;
          REG_DCIC:  dcic_nxt = req.write_value;
          REG_BDAM:  bdam_nxt = req.write_value;
          REG_BPCM:  bpcm_nxt = req.write_value;
          REG_SR:    sr_nxt   = (sr_r & ~sr_wmask) | (req.write_value & sr_wmask);
          REG_CAUSE: cause_nxt = (cause_r & ~cause_wmask) | (req.write_value & cause_wmask);
          default:   wr_ok    = 1'b0;
        endcase
        rsp.bad_access = ~wr_ok;
      end
      OP_EXC: begin
        epc_nxt      = req.fault_pc;
        jumpdest_nxt = req.fault_pc;
        cause_nxt    = '0;
        cause_nxt[CAUSE_CODE_LSB +: CodeW] = req.exc_code;
        cause_nxt[CAUSE_COP_LSB +: CopW]   = req.coproc;
        cause_nxt[CAUSE_BD_BIT]            = req.branch_delay;
        // push kernel/user and interrupt-enable stack
        sr_nxt = ((sr_r & MODE_BITS_MASK) << 2) | (sr_r & PUSH_KEEP_MASK);
      end
      OP_RFE: begin
        // pop the stack
        sr_nxt = ((sr_r >> 2) & MODE_BITS_MASK) | (sr_r & POP_KEEP_MASK);
      end
      default: rsp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r      <= '0;
      bda_r      <= '0;
      jumpdest_r <= '0;
      dcic_r     <= '0;
      bdam_r     <= '0;
      bpcm_r     <= '0;
      sr_r       <= '0;
      cause_r    <= '0;
      epc_r      <= '0;
    end else if (req_fire) begin
      bpc_r      <= bpc_nxt;
      bda_r      <= bda_nxt;
      jumpdest_r <= jumpdest_nxt;
      dcic_r     <= dcic_nxt;
      bdam_r     <= bdam_nxt;
      bpcm_r     <= bpcm_nxt;
      sr_r       <= sr_nxt;
      cause_r    <= cause_nxt;
      epc_r      <= epc_nxt;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the system control coprocessor: directed and random
// register accesses, exception entries and returns under several mask settings,
// checked against a cycle-free model of the coprocessor state
// ----------------------------------------------------------------------------
module testbench;
  import csc_pkg::*;

  // --------------------------------------------------------------------------
  // coprocessor state model and queue of results still to come
  // --------------------------------------------------------------------------
  class csc_scoreboard;
    logic [31:0] sr_mask, cause_mask;
    logic [31:0] bpc, bda, jumpdest, dcic, bdam, bpcm, sr, cause, epc;
    csc_rsp_t    results_due[$];
    int          mismatches;
    int          checked;

    function new();
      sr_mask    = SR_MASK_RST;
      cause_mask = CAUSE_MASK_RST;
      {bpc, bda, jumpdest, dcic, bdam, bpcm, sr, cause, epc} = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_mask(logic idx, logic [31:0] val);
      if (idx == CFG_SR_MASK) sr_mask = val;
      else cause_mask = val;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // update the model for one accepted request and queue its result
    function void note_request(csc_req_t r);
      csc_rsp_t rsp;
      logic [31:0] v;
      rsp = '0;
      v   = r.write_value;
      case (r.op)
        OP_READ: begin
          case (r.reg_index)
            REG_BPC:      rsp.read_data = bpc;
            REG_BDA:      rsp.read_data = bda;
            REG_JUMPDEST: rsp.read_data = jumpdest;
            REG_DCIC:     rsp.read_data = dcic;
            REG_BDAM:     rsp.read_data = bdam;
            REG_BPCM:     rsp.read_data = bpcm;
            REG_SR:       rsp.read_data = sr;
            REG_CAUSE:    rsp.read_data = cause;
            REG_EPC:      rsp.read_data = epc;
            REG_BADVADDR, REG_PRID: rsp.read_data = '0;
            default:      rsp.bad_access = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (r.reg_index)
            REG_BPC:   bpc  = v;
            REG_BDA:   bda  = v;
            REG_DCIC:  dcic = v;
            REG_BDAM:  bdam = v;
            REG_BPCM:  bpcm = v;
            REG_SR:    sr    = (sr & ~sr_mask) | (v & sr_mask);
            REG_CAUSE: cause = (cause & ~cause_mask) | (v & cause_mask);
            default:   rsp.bad_access = 1'b1;
          endcase
        end
        OP_EXC: begin
          epc      = r.fault_pc;
          jumpdest = r.fault_pc;
          cause    = (32'(r.exc_code) << CAUSE_CODE_LSB) | (32'(r.coproc) << CAUSE_COP_LSB)
                   | (32'(r.branch_delay) << CAUSE_BD_BIT);
          sr       = ((sr & MODE_BITS_MASK) << 2) | (sr & PUSH_KEEP_MASK);
        end
        default: begin
          sr = ((sr >> 2) & MODE_BITS_MASK) | (sr & POP_KEEP_MASK);
        end
      endcase
      results_due.push_back(rsp);
    endfunction

    function void check_result(logic [31:0] data, logic bad);
      csc_rsp_t want;
      checked++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected, data %h bad %b", checked, data, bad);
        return;
      end
      want = results_due.pop_front();
      if (want.read_data !== data || want.bad_access !== bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected data %h bad %b, got data %h bad %b",
                   checked, want.read_data, want.bad_access, data, bad);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  csc_scoreboard sb;

  // idling control: no_idle is shared by sender and receiver, hold_requests drives the receiver only
  bit no_idle;
  int hold_requests;

  // cycles since anything was last accepted on either channel
  int stall_cycles;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  cpu_system_control_coprocessor DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // monitors: requests feed the model, results are checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    csc_req_t req;
    if (rst_n && in_tvalid && in_tready) begin
      // unpack tdata from the lowest field up, operation rides in tuser
      req.op           = in_tuser;
      req.reg_index    = in_tdata[5:0];
      req.write_value  = in_tdata[37:6];
      req.fault_pc     = in_tdata[69:38];
      req.exc_code     = in_tdata[74:70];
      req.coproc       = in_tdata[76:75];
      req.branch_delay = in_tdata[77];
      sb.note_request(req);
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** cpu_system_control_coprocessor: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold-off on request so the
  // pipeline fills and back-pressures the request channel
  // --------------------------------------------------------------------------
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one request and wait until it is taken; valid stays high afterwards
  // so that back-to-back requests follow without an idle gap
  task automatic send_request(csc_req_t r);
    if (!no_idle) begin
      while ($urandom_range(99) < 16) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.branch_delay, r.coproc, r.exc_code, r.fault_pc,
                  r.write_value, r.reg_index};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // wait until every result is in; the extra cycles cover the two-stage pipe
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // two-phase register write, only called while the block is idle
  task automatic write_mask(logic idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_mask(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic csc_req_t make_request(logic [1:0] op, logic [5:0] idx,
                                            logic [31:0] wv, logic [31:0] pc,
                                            logic [4:0] code, logic [1:0] cop,
                                            logic bd);
    csc_req_t r;
    r.op           = op;
    r.reg_index    = idx;
    r.write_value  = wv;
    r.fault_pc     = pc;
    r.exc_code     = code;
    r.coproc       = cop;
    r.branch_delay = bd;
    return r;
  endfunction

  // mostly mapped register numbers, sometimes anything in the 6-bit range
  function automatic logic [5:0] pick_index();
    case ($urandom_range(13))
      0:  return REG_BPC;
      1:  return REG_BDA;
      2:  return REG_JUMPDEST;
      3:  return REG_DCIC;
      4:  return REG_BADVADDR;
      5:  return REG_BDAM;
      6:  return REG_BPCM;
      7:  return REG_SR;
      8:  return REG_CAUSE;
      9:  return REG_EPC;
      10: return REG_PRID;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // fields an operation ignores are still randomized
  function automatic csc_req_t random_request();
    csc_req_t r;
    int roll;
    roll = $urandom_range(99);
    r = make_request(OP_READ, pick_index(), pick_word(), pick_word(),
                     5'($urandom_range(31)), 2'($urandom_range(3)),
                     1'($urandom_range(1)));
    if (roll < 35)      r.op = OP_READ;
    else if (roll < 70) r.op = OP_WRITE;
    else if (roll < 85) r.op = OP_EXC;
    else                r.op = OP_RFE;
    return r;
  endfunction

  // handler-shaped burst: trap, inspect the saved state, maybe touch status,
  // then return
  task automatic trap_sequence(inout int sent);
    csc_req_t r;
    int depth;
    depth = $urandom_range(1, 2);
    repeat (depth) begin
      r = random_request(); r.op = OP_EXC; send_request(r); sent++;
    end
    r = random_request(); r.op = OP_READ; r.reg_index = REG_EPC;   send_request(r); sent++;
    r = random_request(); r.op = OP_READ; r.reg_index = REG_CAUSE; send_request(r); sent++;
    if ($urandom_range(1)) begin
      r = random_request(); r.op = OP_WRITE;
      r.reg_index = ($urandom_range(1)) ? REG_SR : REG_CAUSE;
      send_request(r); sent++;
    end
    r = random_request(); r.op = OP_READ; r.reg_index = REG_SR; send_request(r); sent++;
    repeat (depth) begin
      r = random_request(); r.op = OP_RFE; send_request(r); sent++;
    end
    r = random_request(); r.op = OP_READ; r.reg_index = REG_SR; send_request(r); sent++;
  endtask

  task automatic random_items(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) == 0) trap_sequence(sent);
      else begin
        send_request(random_request());
        sent++;
      end
    end
  endtask

  // directed corner cases, run under the default masks
  task automatic directed_items();
    // reads: zero-reading registers, unmapped low and high numbers
    send_request(make_request(OP_READ,  REG_BADVADDR, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ,  REG_PRID,     '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ,  6'd0,         '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ,  6'd63,        '0, '0, '0, '0, 1'b0));
    // plain writes and read back
    send_request(make_request(OP_WRITE, REG_BPC, 32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ,  REG_BPC, '0, '0, '0, '0, 1'b0));
    // masked writes to status and cause
    send_request(make_request(OP_WRITE, REG_SR,    32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_WRITE, REG_CAUSE, 32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ,  REG_CAUSE, '0, '0, '0, '0, 1'b0));
    // writes to read-only and unmapped registers are refused
    send_request(make_request(OP_WRITE, REG_JUMPDEST, 32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_WRITE, REG_EPC,      32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_WRITE, REG_BADVADDR, 32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_WRITE, REG_PRID,     32'hffff_ffff, '0, '0, '0, 1'b0));
    send_request(make_request(OP_WRITE, 6'd63,        32'hffff_ffff, '0, '0, '0, 1'b0));
    // exception entry with every field at its top, ignored fields set too
    send_request(make_request(OP_EXC, 6'd63, 32'hffff_ffff, 32'hffff_ffff,
                              5'd31, 2'd3, 1'b1));
    send_request(make_request(OP_READ, REG_EPC,      '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ, REG_JUMPDEST, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ, REG_CAUSE,    '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ, REG_SR,       '0, '0, '0, '0, 1'b0));
    // return, then an all-zero trap and two returns to drain the mode stack
    send_request(make_request(OP_RFE,  6'd0, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ, REG_SR, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_EXC,  6'd0, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_READ, REG_CAUSE, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_RFE,  6'd0, '0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_RFE,  6'd0, '0, '0, '0, '0, 1'b0));
  endtask

  // --------------------------------------------------------------------------
  // main sequence: one phase per mask setting
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] sr_setting, cause_setting;
    sb            = new();
    no_idle       = 1'b0;
    hold_requests = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_READ;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin sr_setting = SR_MASK_RST;   cause_setting = CAUSE_MASK_RST; end
        1:       begin sr_setting = 32'h0000_0000; cause_setting = 32'h0000_0000;  end
        2:       begin sr_setting = 32'hffff_ffff; cause_setting = 32'hffff_ffff;  end
        default: begin sr_setting = $urandom;      cause_setting = $urandom;       end
      endcase
      drain_results();
      write_mask(CFG_SR_MASK, sr_setting);
      write_mask(CFG_CAUSE_MASK, cause_setting);

      if (phase == 0) directed_items();
      // one phase runs flat out on both sides
      no_idle = (phase == 2);
      // receiver holds off while requests keep coming
      if (phase == 3) hold_requests++;
      random_items(210);
    end

    drain_results();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** cpu_system_control_coprocessor: PASSED **");
    end else begin
      $display("** cpu_system_control_coprocessor: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csc_pkg.sv
hw/rtl/csc_regfile.sv
hw/rtl/cpu_system_control_coprocessor.sv
tb/testbench.sv
